>>> design/wots_base_w_digits_with_checksum_assert.svh
// Assertion macros shared by the checker files of the digit splitter.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef WOTS_BASE_W_DIGITS_WITH_CHECKSUM_ASSERT_SVH
`define WOTS_BASE_W_DIGITS_WITH_CHECKSUM_ASSERT_SVH

// Clocked assertion, off while reset is active.
`define WBWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define WBWC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> design/wbwc_pkg.sv
// Shared types and constants for the base-w digit splitter.
// No dependencies.
package wbwc_pkg;

  // Configuration register indexes
  localparam logic CFG_WIDE_DIGITS = 1'b0;
  localparam logic CFG_CHK_COUNT   = 1'b1;

  localparam logic       WIDE_RESET  = 1'b1;
  localparam logic [3:0] COUNT_RESET = 4'd3;

  localparam int ByteW = 8;
  localparam int AccW  = 16;

  // Per-request control handed from front to back
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       wide;
    logic [3:0] chk_cnt;  // zero unless the request closes a message
  } entry_ctl_t;

endpackage

>>> design/wbwc_fifo.sv
// Small flop-based FIFO between front and back.
// No package dependencies.
module wbwc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> design/wbwc_front.sv
// Front end: accepts digest bytes, keeps the running checksum and builds
// the checksum digit window for closing bytes. Uses wbwc_pkg.
module wbwc_front import wbwc_pkg::*; #(
  parameter int MaxDigits = 8,
  parameter int WinW      = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       msg_byte_i,
  input  logic             last_byte_i,
  input  logic             wide_i,
  input  logic [3:0]       count_i,
  output entry_ctl_t       ctl_o,
  output logic [WinW-1:0]  win_o
);
  localparam int CalcW = (WinW > AccW + ByteW) ? WinW : AccW + ByteW;

  logic [AccW-1:0]  acc_q, acc_d, acc_sat;
  logic [4:0]       byte_sum;
  logic [AccW:0]    acc_sum;
  logic [3:0]       cnt_clamp;
  logic [5:0]       total_bits;
  logic [2:0]       nbytes;
  logic [3:0]       shamt;
  logic [5:0]       keep_bits;
  logic [CalcW-1:0] shifted, keep, aligned;

  // Checksum contribution of a whole byte: sum of (w-1-digit)
  always_comb begin
    if (wide_i) begin
      byte_sum = 5'(4'hF - msg_byte_i[7:4]) + 5'(4'hF - msg_byte_i[3:0]);
    end else begin
      byte_sum = 5'(2'd3 - msg_byte_i[7:6]) + 5'(2'd3 - msg_byte_i[5:4])
               + 5'(2'd3 - msg_byte_i[3:2]) + 5'(2'd3 - msg_byte_i[1:0]);
    end
    acc_sum = {1'b0, acc_q} + (AccW+1)'(byte_sum);
    // contributions are nonnegative, so one final clamp equals per-digit saturation
    acc_sat = acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
    acc_d   = last_byte_i ? '0 : acc_sat;
  end

  // Checksum window, left aligned so the back end reads from the top
  always_comb begin
    cnt_clamp  = (count_i > 4'(MaxDigits)) ? 4'(MaxDigits) : count_i;
    total_bits = wide_i ? {cnt_clamp, 2'b00} : {1'b0, cnt_clamp, 1'b0};
    nbytes     = 3'((total_bits + 6'd7) >> 3);
    shamt      = 4'd8 - {1'b0, total_bits[2:0]};
    keep_bits  = {nbytes, 3'b000};
    shifted    = CalcW'(acc_sat) << shamt;
    keep       = (CalcW'(1) << keep_bits) - CalcW'(1);
    aligned    = (shifted & keep) << (7'(CalcW) - {1'b0, keep_bits});
  end

  assign ctl_o.msg_byte = msg_byte_i;
  assign ctl_o.wide     = wide_i;
  assign ctl_o.chk_cnt  = last_byte_i ? cnt_clamp : 4'd0;
  assign win_o          = aligned[CalcW-1 -: WinW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (accept_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

>>> design/wbwc_back.sv
// Back end: plays out one digit per cycle, while the output is not stalled,
// from the queued request into the output register. Uses wbwc_pkg.
module wbwc_back import wbwc_pkg::*; #(
  parameter int WinW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  entry_ctl_t      q_ctl_i,
  input  logic [WinW-1:0] q_win_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [3:0]      digit_o,
  output logic            is_checksum_o,
  output logic            end_of_run_o
);
  logic [7:0]      byte_q, byte_d;
  logic [WinW-1:0] win_q, win_d;
  logic            wide_q, wide_d;
  logic [2:0]      msg_cnt_q, msg_cnt_d;
  logic [3:0]      chk_cnt_q, chk_cnt_d;
  logic            active, out_free, emit, done, in_msg;
  logic [3:0]      cur_digit;
  logic            cur_eor;
  logic            ovalid_q, ovalid_d;
  logic [3:0]      odigit_q;
  logic            ochk_q, oeor_q;

  assign active   = (msg_cnt_q != '0) || (chk_cnt_q != '0);
  assign in_msg   = (msg_cnt_q != '0);
  assign out_free = !ovalid_q || !out_stall_i;
  assign emit     = active && out_free;
  assign cur_eor  = (msg_cnt_q == 3'd1 && chk_cnt_q == '0) ||
                    (msg_cnt_q == '0 && chk_cnt_q == 4'd1);
  assign done     = emit && cur_eor;
  assign q_pop_o  = q_valid_i && (!active || done);

  always_comb begin
    if (in_msg) begin
      cur_digit = wide_q ? byte_q[7:4] : {2'b00, byte_q[7:6]};
    end else begin
      cur_digit = wide_q ? win_q[WinW-1 -: 4] : {2'b00, win_q[WinW-1 -: 2]};
    end
  end

  always_comb begin
    byte_d    = byte_q;
    win_d     = win_q;
    wide_d    = wide_q;
    msg_cnt_d = msg_cnt_q;
    chk_cnt_d = chk_cnt_q;
    if (q_pop_o) begin
      byte_d    = q_ctl_i.msg_byte;
      win_d     = q_win_i;
      wide_d    = q_ctl_i.wide;
      msg_cnt_d = q_ctl_i.wide ? 3'd2 : 3'd4;
      chk_cnt_d = q_ctl_i.chk_cnt;
    end else if (emit) begin
      if (in_msg) begin
        byte_d    = wide_q ? (byte_q << 4) : (byte_q << 2);
        msg_cnt_d = msg_cnt_q - 3'd1;
      end else begin
        win_d     = wide_q ? (win_q << 4) : (win_q << 2);
        chk_cnt_d = chk_cnt_q - 4'd1;
      end
    end
    ovalid_d = out_free ? emit : ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_cnt_q <= '0;
      chk_cnt_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      msg_cnt_q <= msg_cnt_d;
      chk_cnt_q <= chk_cnt_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    win_q  <= win_d;
    wide_q <= wide_d;
    if (emit) begin
      odigit_q <= cur_digit;
      ochk_q   <= !in_msg;
      oeor_q   <= cur_eor;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign digit_o       = odigit_q;
  assign is_checksum_o = ochk_q;
  assign end_of_run_o  = oeor_q;

endmodule

>>> design/wots_base_w_digits_with_checksum.sv
// WOTS+ base-w digit splitter with checksum digits. Each request carries
// one digest byte and yields its base-w digits, most significant first:
// four 2-bit digits (w=4) or two 4-bit digits (w=16). A byte flagged last
// is followed by checksum_digit_count checksum digits (clamped to
// MAX_CHECKSUM_DIGITS, none for a count of zero), read from the saturating
// 16-bit checksum shifted left by 8-((count*log2w) mod 8) and cut to whole
// bytes, the RFC 8391 form. The checksum then clears. Rate: one digit per
// cycle out of the back end while the output is not stalled; the digit
// playout loop in the back end sets this. Requests are taken while the
// back end is busy until the QUEUE_DEPTH-entry queue is full. A request
// passes through the queue and the back-end registers before its first
// digit is registered in the output register. Configuration writes are
// taken every cycle and must only be issued while the block is idle.
// Uses wbwc_pkg, wbwc_front, wbwc_fifo and wbwc_back.
module wots_base_w_digits_with_checksum import wbwc_pkg::*; #(
  parameter int MAX_CHECKSUM_DIGITS = 8,
  parameter int QUEUE_DEPTH         = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] msg_byte_i,
  input  logic       last_byte_i,
  // digit channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] digit_o,
  output logic       is_checksum_o,
  output logic       end_of_run_o,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [3:0] cfg_data_i
);
  // Checksum window: whole bytes covering the largest digit count at w=16
  localparam int WinW = ((MAX_CHECKSUM_DIGITS * 4 + 7) / 8) * 8;
  localparam int CtlW = $bits(entry_ctl_t);
  localparam int EntW = CtlW + WinW;

  logic             wide_q;
  logic [3:0]       count_q;
  logic             accept, q_full, q_valid, q_pop;
  entry_ctl_t       f_ctl, q_ctl;
  logic [WinW-1:0]  f_win, q_win;
  logic [EntW-1:0]  q_rdata;

  // Configuration registers, written any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q  <= WIDE_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WIDE_DIGITS: wide_q  <= cfg_data_i[0];
        CFG_CHK_COUNT:   count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end only stalls on a full queue
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  wbwc_front #(
    .MaxDigits (MAX_CHECKSUM_DIGITS),
    .WinW      (WinW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .msg_byte_i  (msg_byte_i),
    .last_byte_i (last_byte_i),
    .wide_i      (wide_q),
    .count_i     (count_q),
    .ctl_o       (f_ctl),
    .win_o       (f_win)
  );

  wbwc_fifo #(
    .Width (EntW),
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i ({f_ctl, f_win}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign q_ctl = q_rdata[EntW-1 -: CtlW];
  assign q_win = q_rdata[WinW-1:0];

  wbwc_back #(
    .WinW (WinW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ctl_i       (q_ctl),
    .q_win_i       (q_win),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digit_o       (digit_o),
    .is_checksum_o (is_checksum_o),
    .end_of_run_o  (end_of_run_o)
  );

endmodule

>>> design/wbwc_checker.sv
// Port-level checker for the digit splitter, bound to the top level.
// Uses the assertion macros header.
`include "wots_base_w_digits_with_checksum_assert.svh"

module wbwc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] digit_o,
  input logic       is_checksum_o,
  input logic       end_of_run_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic       cfg_index_i,
  input logic [3:0] cfg_data_i
);
  logic       wide_q;
  logic [7:0] pend_q;
  logic       in_acc, run_done;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign run_done = out_valid_o && !out_stall_i && end_of_run_o;

  // shadow of the digit width setting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o && !cfg_index_i) begin
      wide_q <= cfg_data_i[0];
    end
  end

  // requests whose last digit is not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_acc) - 8'(run_done);
    end
  end

  `WBWC_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_o) &&
      $stable(is_checksum_o) && $stable(end_of_run_o),
    "stalled digit changed")
  `WBWC_ASSERT(a_no_orphan, out_valid_o |-> pend_q != 8'd0, "digit without pending request")
  `WBWC_ASSERT(a_narrow_range, out_valid_o && !wide_q |-> digit_o[3:2] == 2'b00, "digit out of range for w=4")
  `WBWC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "digit shown in reset")

endmodule

bind wots_base_w_digits_with_checksum wbwc_checker u_wbwc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digit_o       (digit_o),
  .is_checksum_o (is_checksum_o),
  .end_of_run_o  (end_of_run_o),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i)
);
